// ===== hw/rtl/sass_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sass_pkg;

	// Fixed field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LEN_W    = 11;
	localparam int unsigned SCALE_W  = 24;
	localparam int unsigned RESULT_W = 32;
	localparam int unsigned FRAC_W   = 16;   // Q8.16 coefficient
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REDUCE_LEN = 2'd0,
		CFG_INNER_LEN  = 2'd1,
		CFG_SCALE      = 2'd2
	} cfg_index_t;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

endpackage

`default_nettype wire

// ===== hw/rtl/strided_axis_sum_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// -------   ---  ---------------------  ---------------------------------------
// s_*       in   s_tvalid / s_tready    s_tdata = sample (16b signed)
// m_*       out  m_tvalid / m_tready    m_tdata = result (32b signed),
//                                       m_tlast = last_of_group
// cfg_*     in   cfg_we (no wait)       cfg_index, cfg_data (24b)
//
// One request per cycle sustained while m_tready does not stall a producing item;
// the accumulator RAM port pair (one read at accept, one write as the item leaves
// stage 1) sets that figure. A result goes from the RAM read at the accept edge
// through add, multiply, and round/saturate into the output register. Reset clears
// counters and pipeline valids; the accumulator RAM has no clear, since the first
// row of each group writes every entry before any later row reads it. Stalls on
// m_tready collapse bubbles stage by stage; items that produce no result retire
// after their write-back and never wait on the output.
module strided_axis_sum_scale #(
	parameter int unsigned MAX_INNER  = 1024,
	parameter int unsigned MAX_REDUCE = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [sass_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sass_pkg::SCALE_W-1:0]       cfg_data,
	// input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [sass_pkg::SAMPLE_W-1:0]      s_tdata,  // [15:0] sample
	// output stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [sass_pkg::RESULT_W-1:0]      m_tdata,  // [31:0] result
	output logic                                    m_tlast   // last_of_group
);

	localparam int unsigned CW     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int unsigned RW     = (MAX_REDUCE > 1) ? $clog2(MAX_REDUCE) : 1;
	// Sum of up to MAX_REDUCE 16-bit samples
	localparam int unsigned ACC_W  = sass_pkg::SAMPLE_W + $clog2(MAX_REDUCE);
	localparam int unsigned PROD_W = ACC_W + sass_pkg::SCALE_W;
	localparam int unsigned RND_W  = PROD_W + 1;
	localparam int unsigned Q_W    = RND_W - sass_pkg::FRAC_W;
	localparam int unsigned QX_W   = (Q_W > 33) ? Q_W : 33;
	localparam int unsigned RES_W  = sass_pkg::RESULT_W;

	// Length minus one, with zero acting as one and overflow clamped.
	function automatic logic [31:0] len_m1(input logic [sass_pkg::LEN_W-1:0] v,
			input int unsigned maxv);
		logic [31:0] r;
		if (v == '0) begin
			r = '0;
		end else if (32'(v) > maxv) begin
			r = maxv - 1;
		end else begin
			r = 32'(v) - 32'd1;
		end
		return r;
	endfunction

	// ---------------- configuration and position counters ----------------
	logic [RW-1:0]                          rows_m1_q;
	logic [CW-1:0]                          cols_m1_q;
	logic signed [sass_pkg::SCALE_W-1:0]    scale_q;
	logic [RW-1:0]                          row_q;
	logic [CW-1:0]                          col_q;

	logic accept;
	logic last_row, last_col;

	assign last_row = (row_q == rows_m1_q);
	assign last_col = (col_q == cols_m1_q);

	// ---------------- pipeline state ----------------
	logic                                   valid_s1;
	logic signed [sass_pkg::SAMPLE_W-1:0]   sample_s1;
	logic [CW-1:0]                          col_s1;
	logic                                   first_s1;  // first row: overwrite
	logic                                   prod_s1;   // last row: emit result
	logic                                   last_s1;   // last column of its row
	logic                                   fwd_s1;    // RAM data is stale
	logic signed [ACC_W-1:0]                fwd_sum_q;

	logic                                   valid_s2;
	logic signed [ACC_W-1:0]                sum_s2;
	logic                                   last_s2;

	logic                                   valid_s3;
	logic signed [PROD_W-1:0]               prod_s3;
	logic                                   last_s3;

	logic                                   out_valid_q;
	logic [RES_W-1:0]                       out_data_q;
	logic                                   out_last_q;

	// ---------------- handshake chain ----------------
	logic out_free, rdy3, rdy2, rdy1, adv1;

	assign out_free = !out_valid_q || m_tready;
	assign rdy3     = !valid_s3 || out_free;
	assign rdy2     = !valid_s2 || rdy3;
	// a non-producing item only needs its write-back to retire
	assign rdy1     = !valid_s1 || !prod_s1 || rdy2;
	assign adv1     = valid_s1 && (!prod_s1 || rdy2);

	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;

	// ---------------- accumulator RAM ----------------
	logic [ACC_W-1:0]        ram_rdata;
	logic signed [ACC_W-1:0] acc_old;
	logic signed [ACC_W-1:0] sum1;

	sass_ram #(
		.WIDTH(ACC_W),
		.DEPTH(MAX_INNER)
	) u_acc_ram (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (sum1),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// Take the previous sum directly when it was written back in the same
	// edge this entry was read (back-to-back requests on one column).
	always_comb begin
		if (first_s1) begin
			acc_old = '0;
		end else if (fwd_s1) begin
			acc_old = fwd_sum_q;
		end else begin
			acc_old = $signed(ram_rdata);
		end
		sum1 = acc_old + ACC_W'(sample_s1);
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q <= '0;
			cols_m1_q <= '0;
			scale_q   <= $signed(sass_pkg::SCALE_RESET);
			row_q     <= '0;
			col_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sass_pkg::CFG_REDUCE_LEN: begin
					rows_m1_q <= RW'(len_m1(cfg_data[sass_pkg::LEN_W-1:0], MAX_REDUCE));
					row_q     <= '0;
					col_q     <= '0;
				end
				sass_pkg::CFG_INNER_LEN: begin
					cols_m1_q <= CW'(len_m1(cfg_data[sass_pkg::LEN_W-1:0], MAX_INNER));
					row_q     <= '0;
					col_q     <= '0;
				end
				sass_pkg::CFG_SCALE: begin
					scale_q <= $signed(cfg_data);
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end else if (accept) begin
			// advance column, wrap into the next row or the next group
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------- stage 1: read data back, add ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= $signed(s_tdata);
			col_s1    <= col_q;
			first_s1  <= (row_q == '0);
			prod_s1   <= last_row;
			last_s1   <= last_col;
			fwd_s1    <= valid_s1 && adv1 && (col_s1 == col_q);
		end
		if (adv1) begin
			fwd_sum_q <= sum1;
		end
	end

	// ---------------- stage 2: sum register, multiply ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1 && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1 && prod_s1) begin
			sum_s2  <= sum1;
			last_s2 <= last_s1;
		end
	end

	// ---------------- stage 3: product register ----------------
	logic signed [PROD_W-1:0] prod_mul;
	assign prod_mul = sum_s2 * scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			prod_s3 <= prod_mul;
			last_s3 <= last_s2;
		end
	end

	// ---------------- round to nearest (ties up), saturate ----------------
	logic signed [RND_W-1:0] rnd;
	logic signed [Q_W-1:0]   quo;
	logic signed [QX_W-1:0]  quo_x;
	logic [RES_W-1:0]        res_sat;

	always_comb begin
		rnd   = RND_W'(prod_s3) + RND_W'(32'sd1 <<< (sass_pkg::FRAC_W - 1));
		quo   = Q_W'(rnd >>> sass_pkg::FRAC_W);
		quo_x = QX_W'(quo);
		if ((&quo_x[QX_W-1:RES_W-1]) || !(|quo_x[QX_W-1:RES_W-1])) begin
			res_sat = quo_x[RES_W-1:0];
		end else if (quo_x[QX_W-1]) begin
			res_sat = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			res_sat = {1'b0, {(RES_W-1){1'b1}}};
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			out_data_q <= res_sat;
			out_last_q <= last_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// ---------------- assertions ----------------
	// Counters never run past the configured shape.
	a_counters_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= rows_m1_q) && (col_q <= cols_m1_q))
		else $error("position counter beyond configured shape");

	// Forwarding only arises when a row is a single column wide.
	a_fwd_single_col: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> (cols_m1_q == '0))
		else $error("forwarding on a multi-column row");

	// A held stage 1 item blocks new requests, keeping RAM read data stable.
	a_hold_blocks_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |-> !accept)
		else $error("request accepted while stage 1 holds");

	// Last column of a row wraps the column counter.
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_col && !cfg_we) |=> (col_q == '0))
		else $error("column counter failed to wrap");

	// Only producing items enter the scaling stages.
	a_s2_from_prod: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy2 && valid_s1 && !prod_s1) |=> !valid_s2)
		else $error("non-producing item entered scaling stage");

endmodule

`default_nettype wire

// ===== hw/rtl/sass_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one read port, registered read.
module sass_ram #(
	parameter int unsigned WIDTH = 26,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
